/* hw/rtl/gcnco_pkg.sv */
// Shared types, constants and helper functions of the GPS code NCO.
`timescale 1ns / 1ps

package gcnco_pkg;

    localparam int CODE_LEN   = 1023;
    localparam int CHIP_W     = 10;
    localparam int LINE_LEN   = 64;
    localparam int TAP_W      = 6;
    localparam int PROMPT_POS = 32;
    localparam int PHASE_W    = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [CHIP_W-1:0] t_chip;
    typedef logic [TAP_W-1:0]  t_tap_pos;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_INIT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_EL_OFFSET  = 2'd1,
        REG_NOISE_OFS  = 2'd2
    } t_reg_idx;

    // Control from the init sequencer to the datapath.
    typedef struct packed {
        logic  reading;
        logic  fill;
        logic  busy;
        t_chip addr;
    } t_init_ctl;

    // Reduce a 10-bit value modulo the code length.
    function automatic t_chip f_mod_code(input t_chip v);
        f_mod_code = (v == t_chip'(CODE_LEN)) ? '0 : v;
    endfunction

    // Advance a chip index by one, wrapping at the code length.
    function automatic t_chip f_chip_inc(input t_chip v);
        f_chip_inc = (v == t_chip'(CODE_LEN - 1)) ? '0 : v + t_chip'(1);
    endfunction

endpackage

/* hw/rtl/gcnco_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module gcnco_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1023
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gcnco_cfg.sv */
// APB-style configuration registers of the GPS code NCO.
`timescale 1ns / 1ps

module gcnco_cfg
    import gcnco_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PHASE_W-1:0]    o_phase_step,
    output logic [4:0]            o_el_offset,
    output logic [5:0]            o_noise_offset
);

    logic [PHASE_W-1:0] r_phase_step;
    logic [4:0]         r_el_offset;
    logic [5:0]         r_noise_offset;
    logic               wr_en;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_el_offset    <= 5'd8;
            r_noise_offset <= 6'd32;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PHASE_STEP: r_phase_step   <= pwdata;
                REG_EL_OFFSET:  r_el_offset    <= pwdata[4:0];
                REG_NOISE_OFS:  r_noise_offset <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PHASE_STEP: prdata = r_phase_step;
            REG_EL_OFFSET:  prdata = {27'd0, r_el_offset};
            REG_NOISE_OFS:  prdata = {26'd0, r_noise_offset};
            default:        prdata = '0;
        endcase
    end

    assign o_phase_step   = r_phase_step;
    assign o_el_offset    = r_el_offset;
    assign o_noise_offset = r_noise_offset;

endmodule

/* hw/rtl/gcnco_init_seq.sv */
// Init sequencer: sweeps 64 code memory addresses to prefill the delay line.
`timescale 1ns / 1ps

module gcnco_init_seq
    import gcnco_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_chip     i_start_chip,
    input  t_chip     i_travel_delay,
    output t_init_ctl o_ctl
);

    localparam int CNT_W = $clog2(LINE_LEN);

    logic             r_reading;
    logic             r_fill;
    logic [CNT_W-1:0] r_cnt;
    t_chip            r_addr;

    logic [CHIP_W:0]  diff;
    t_chip            part;
    logic [CHIP_W:0]  diff2;
    t_chip            base;

    // Oldest line bit comes from chip - delay - 32, taken modulo the code length.
    always_comb begin
        diff  = {1'b0, f_mod_code(i_start_chip)} - {1'b0, f_mod_code(i_travel_delay)};
        part  = diff[CHIP_W] ? CHIP_W'(diff + (CHIP_W+1)'(CODE_LEN)) : diff[CHIP_W-1:0];
        diff2 = {1'b0, part} - (CHIP_W+1)'(PROMPT_POS);
        base  = diff2[CHIP_W] ? CHIP_W'(diff2 + (CHIP_W+1)'(CODE_LEN)) : diff2[CHIP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_fill    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_fill <= r_reading;
            if (i_start) begin
                r_reading <= 1'b1;
                r_cnt     <= '0;
            end else if (r_reading) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LINE_LEN - 1)) begin
                    r_reading <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= base;
        end else if (r_reading) begin
            r_addr <= f_chip_inc(r_addr);
        end
    end

    assign o_ctl.reading = r_reading;
    assign o_ctl.fill    = r_fill;
    assign o_ctl.busy    = r_reading || r_fill;
    assign o_ctl.addr    = r_addr;

endmodule

/* hw/rtl/gps_code_nco_epl_taps_top.sv */
// Top level of the GPS code NCO with early, prompt and late delay-line taps.
// A tick word's result passes through the code memory read stage and then the output register.
// Throughput: one tick or load word per cycle while no init sweep or stalled output holds the input.
// An init word holds the input stalled while 64 code chips are read out into the delay line.
// Synchronous active-low reset clears phase, chip counter, delay line and valid flags and
// presets the registers; the code memory is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module gps_code_nco_epl_taps_top
    import gcnco_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    input  logic [9:0]            i_chip_addr,
    input  logic                  i_chip_value,
    input  logic [9:0]            i_start_chip,
    input  logic [31:0]           i_start_fraction,
    input  logic [9:0]            i_travel_delay,
    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [9:0]            o_table_index,
    output logic [9:0]            o_chip_index,
    output logic                  o_early,
    output logic                  o_prompt,
    output logic                  o_late,
    output logic                  o_super_early,
    output logic                  o_super_late,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The table index is the top INDEX_BITS of the phase, kept to the 10-bit field.
    localparam int TBL_SHIFT = PHASE_W - INDEX_BITS;

    // Configuration values.
    logic [PHASE_W-1:0]  phase_step;
    logic [4:0]          el_offset;
    logic [5:0]          noise_offset;

    // NCO state. The code itself lives in the RAM; the delay line in flops.
    logic [PHASE_W-1:0]  r_phase;
    t_chip               r_chip;
    logic [LINE_LEN-1:0] r_line;

    // Stage one: code memory read in flight for an accepted tick.
    logic                r_s1_valid;
    logic [9:0]          r_s1_tbl;
    t_chip               r_s1_chip;

    // Output register.
    logic                r_out_valid;
    logic [9:0]          r_out_tbl;
    t_chip               r_out_chip;
    logic                r_out_early;
    logic                r_out_prompt;
    logic                r_out_late;
    logic                r_out_se;
    logic                r_out_sl;

    t_init_ctl           init_ctl;
    logic                accept;
    logic                acc_tick;
    logic                acc_load;
    logic                acc_init;
    logic                s1_adv;
    logic [PHASE_W:0]    phase_sum;
    logic [PHASE_W-1:0]  n_phase;
    t_chip               n_chip;
    logic [9:0]          n_tbl;
    logic                ram_rdata;
    logic                ram_re;
    t_chip               ram_raddr;
    logic                ram_we;
    logic [LINE_LEN-1:0] n_line;
    t_tap_pos            pos_early;
    t_tap_pos            pos_late;
    t_tap_pos            pos_se;
    t_tap_pos            pos_sl;

    gcnco_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_phase_step   (phase_step),
        .o_el_offset    (el_offset),
        .o_noise_offset (noise_offset)
    );

    // Stage one advances into the output register whenever that register is
    // empty or being drained this cycle.
    assign s1_adv = r_s1_valid && !(r_out_valid && i_out_stall);

    // The input stalls during an init sweep, when a pending tick cannot move
    // on, and for an init word while a tick still has to shift the line: the
    // init fill would otherwise collide with that shift.
    assign o_in_stall = init_ctl.busy
                     || (r_s1_valid && r_out_valid && i_out_stall)
                     || (r_s1_valid && (i_action == ACT_INIT));

    assign accept   = i_in_valid && !o_in_stall;
    assign acc_tick = accept && (i_action == ACT_TICK);
    assign acc_load = accept && (i_action == ACT_LOAD);
    assign acc_init = accept && (i_action == ACT_INIT);

    // Phase step; a carry out of the accumulator advances the chip counter.
    always_comb begin
        phase_sum = {1'b0, r_phase} + {1'b0, phase_step};
        n_phase   = phase_sum[PHASE_W-1:0];
        n_chip    = phase_sum[PHASE_W] ? f_chip_inc(r_chip) : r_chip;
        n_tbl     = 10'(n_phase >> TBL_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_chip  <= '0;
        end else if (acc_tick) begin
            r_phase <= n_phase;
            r_chip  <= n_chip;
        end else if (acc_init) begin
            r_phase <= i_start_fraction;
            r_chip  <= f_mod_code(i_start_chip);
        end
    end

    gcnco_init_seq u_init_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (acc_init),
        .i_start_chip   (i_start_chip),
        .i_travel_delay (i_travel_delay),
        .o_ctl          (init_ctl)
    );

    // The code memory read port serves the chip of a new tick, or the sweep
    // address during an init. A load of the out-of-range address is dropped.
    assign ram_re    = acc_tick || init_ctl.reading;
    assign ram_raddr = init_ctl.reading ? init_ctl.addr : n_chip;
    assign ram_we    = acc_load && (i_chip_addr != t_chip'(CODE_LEN));

    gcnco_ram #(
        .WIDTH (1),
        .DEPTH (CODE_LEN)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_chip_addr),
        .i_wdata (i_chip_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_tick) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_tick) begin
            r_s1_tbl  <= n_tbl;
            r_s1_chip <= n_chip;
        end
    end

    // A tick shifts the new chip in at bit 0. The init fill shifts in from the
    // top, so after 64 reads bit i holds the i-th chip of the sweep.
    assign n_line = {r_line[LINE_LEN-2:0], ram_rdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (init_ctl.fill) begin
            r_line <= {ram_rdata, r_line[LINE_LEN-1:1]};
        end else if (s1_adv) begin
            r_line <= n_line;
        end
    end

    // Tap positions around the prompt bit; the noise taps clamp at the ends.
    always_comb begin
        pos_early = t_tap_pos'(PROMPT_POS) - {1'b0, el_offset};
        pos_late  = t_tap_pos'(PROMPT_POS) + {1'b0, el_offset};
        pos_se    = noise_offset[5] ? '0 : t_tap_pos'(PROMPT_POS) - noise_offset;
        pos_sl    = noise_offset[5] ? t_tap_pos'(LINE_LEN - 1)
                                    : t_tap_pos'(PROMPT_POS) + noise_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_tbl    <= r_s1_tbl;
            r_out_chip   <= r_s1_chip;
            r_out_early  <= n_line[pos_early];
            r_out_prompt <= n_line[PROMPT_POS];
            r_out_late   <= n_line[pos_late];
            r_out_se     <= n_line[pos_se];
            r_out_sl     <= n_line[pos_sl];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_table_index = r_out_tbl;
    assign o_chip_index  = r_out_chip;
    assign o_early       = r_out_early;
    assign o_prompt      = r_out_prompt;
    assign o_late        = r_out_late;
    assign o_super_early = r_out_se;
    assign o_super_late  = r_out_sl;

`ifndef SYNTH
    // A pending tick never sits beside an init sweep in the delay line path.
    a_no_tick_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && init_ctl.busy))
        else $error("tick in flight during init sweep");

    // An accepted init starts the code memory sweep in the next cycle.
    a_init_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_init |=> init_ctl.reading)
        else $error("init accepted without sweep");

    // A tick whose output slot is free reaches the output register next cycle.
    a_tick_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("tick result lost between stages");

    // The chip counter always stays within the code length.
    a_chip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chip != t_chip'(CODE_LEN))
        else $error("chip counter out of range");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the GPS code NCO with early, prompt and late delay-line taps.
`timescale 1ns / 1ps

module tb_top
    import gcnco_pkg::*;
();

    // The block is built with the default table index width; the checker
    // derives the expected table index from the same value.
    localparam int IDX_BITS = 10;

    // Quiet-cycle count at which the watchdog gives up. The slowest legal
    // stretch without traffic is the long output hold-off below, well short of this.
    localparam int WATCHDOG_LIMIT = 3000;

    // An init word keeps the block busy through its code memory sweep without producing
    // a result, so a register write waits long enough after the last result for it to end.
    localparam int SETTLE_CYCLES = 80;

    // Length of the long output hold-off used to fill the block.
    localparam int HOLD_OFF_CYCLES = 300;

    // Index of a register that does not exist; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Action code that the block does not use; such a word must change nothing.
    localparam logic [1:0] ACT_NONE = 2'd3;

    // One result word as the block presents it.
    typedef struct {
        logic [9:0] table_index;
        t_chip      chip_index;
        logic       early;
        logic       prompt;
        logic       late;
        logic       super_early;
        logic       super_late;
    } t_nco_taps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_action;
    logic [9:0]            i_chip_addr;
    logic                  i_chip_value;
    logic [9:0]            i_start_chip;
    logic [31:0]           i_start_fraction;
    logic [9:0]            i_travel_delay;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [9:0]            o_table_index;
    logic [9:0]            o_chip_index;
    logic                  o_early;
    logic                  o_prompt;
    logic                  o_late;
    logic                  o_super_early;
    logic                  o_super_late;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Our own copy of the NCO: registers, running state and the code memory.
    logic [31:0] cfg_step;
    logic [4:0]  cfg_el_ofs;
    logic [5:0]  cfg_noise_ofs;
    logic [31:0] nco_phase;
    t_chip       nco_chip;
    logic [63:0] code_line;
    logic        code_chips [0:CODE_LEN-1];

    // Tap words that the block still owes us, oldest first.
    t_nco_taps expected_taps[$];

    int err_count;
    int results_checked;
    int ticks_sent;
    int loads_sent;
    int inits_sent;
    int noops_sent;

    // When set, neither side inserts random gaps or stalls.
    bit quiet;
    // Asks the output side for one long hold-off.
    bit hold_req;

    gps_code_nco_epl_taps_top #(
        .INDEX_BITS(IDX_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_chip_addr     (i_chip_addr),
        .i_chip_value    (i_chip_value),
        .i_start_chip    (i_start_chip),
        .i_start_fraction(i_start_fraction),
        .i_travel_delay  (i_travel_delay),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_table_index   (o_table_index),
        .o_chip_index    (o_chip_index),
        .o_early         (o_early),
        .o_prompt        (o_prompt),
        .o_late          (o_late),
        .o_super_early   (o_super_early),
        .o_super_late    (o_super_late),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length shared by both sides: mostly none, often a few cycles,
    // and now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Advance our copy of the NCO by one accepted input word and queue the
    // tap word that a tick produces.
    task automatic predict_taps(input logic [1:0] act, input t_chip addr, input logic val,
                                input t_chip start, input logic [31:0] frac,
                                input t_chip delay);
        logic [32:0] sum;
        t_nco_taps   taps;
        int          k;
        int          src;
        int          se_pos;
        int          sl_pos;
        case (act)
            ACT_LOAD: begin
                // An address past the end of the code is dropped.
                if (int'(addr) < CODE_LEN) begin
                    code_chips[addr] = val;
                end
                loads_sent++;
            end
            ACT_INIT: begin
                nco_phase = frac;
                nco_chip  = (int'(start) == CODE_LEN) ? '0 : start;
                // Prefill the line so that bit 32 holds the chip at the
                // current counter minus the travel delay, wrapping around the code.
                for (k = 0; k < LINE_LEN; k++) begin
                    src = (int'(nco_chip) + 2 * CODE_LEN - int'(delay) - PROMPT_POS + k)
                          % CODE_LEN;
                    code_line[k] = code_chips[src];
                end
                inits_sent++;
            end
            ACT_TICK: begin
                sum       = {1'b0, nco_phase} + {1'b0, cfg_step};
                nco_phase = sum[31:0];
                if (sum[32]) begin
                    nco_chip = (int'(nco_chip) == CODE_LEN - 1) ? '0 : nco_chip + 1'b1;
                end
                code_line = {code_line[62:0], code_chips[nco_chip]};
                // Noise taps are clamped to the ends of the line.
                se_pos = (int'(cfg_noise_ofs) >= PROMPT_POS) ? 0
                                                             : PROMPT_POS - int'(cfg_noise_ofs);
                sl_pos = (PROMPT_POS + int'(cfg_noise_ofs) > LINE_LEN - 1) ? LINE_LEN - 1
                                                             : PROMPT_POS + int'(cfg_noise_ofs);
                taps.table_index = 10'(nco_phase >> (PHASE_W - IDX_BITS));
                taps.chip_index  = nco_chip;
                taps.early       = code_line[PROMPT_POS - int'(cfg_el_ofs)];
                taps.prompt      = code_line[PROMPT_POS];
                taps.late        = code_line[PROMPT_POS + int'(cfg_el_ofs)];
                taps.super_early = code_line[se_pos];
                taps.super_late  = code_line[sl_pos];
                expected_taps.push_back(taps);
                ticks_sent++;
            end
            default: begin
                noops_sent++;
            end
        endcase
    endtask

    // Offer one input word and return once the block has taken it. Valid is
    // left high so that back-to-back words need no extra edge.
    task automatic send_word(input logic [1:0] act, input t_chip addr, input logic val,
                             input t_chip start, input logic [31:0] frac,
                             input t_chip delay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_chip_addr      <= addr;
        i_chip_value     <= val;
        i_start_chip     <= start;
        i_start_fraction <= frac;
        i_travel_delay   <= delay;
        do @(posedge i_clk); while (o_in_stall);
        predict_taps(act, addr, val, start, frac, delay);
    endtask

    // The fields that an action does not use carry random noise.
    task automatic send_tick();
        send_word(ACT_TICK, 10'($urandom), 1'($urandom), 10'($urandom), $urandom,
                  10'($urandom));
    endtask

    task automatic send_load(input t_chip addr, input logic val);
        send_word(ACT_LOAD, addr, val, 10'($urandom), $urandom, 10'($urandom));
    endtask

    task automatic send_init(input t_chip start, input logic [31:0] frac, input t_chip delay);
        send_word(ACT_INIT, 10'($urandom), 1'($urandom), start, frac, delay);
    endtask

    task automatic send_noop();
        send_word(ACT_NONE, 10'($urandom), 1'($urandom), 10'($urandom), $urandom,
                  10'($urandom));
    endtask

    // Bring the block to rest: every owed result has arrived and any init
    // still walking the code has finished.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PHASE_STEP: cfg_step      = value;
            REG_EL_OFFSET:  cfg_el_ofs    = value[4:0];
            REG_NOISE_OFS:  cfg_noise_ofs = value[5:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] step, input logic [4:0] el_ofs,
                              input logic [5:0] noise_ofs);
        settle();
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_EL_OFFSET, 32'(el_ofs));
        write_reg(REG_NOISE_OFS, 32'(noise_ofs));
    endtask

    // Fill the whole code memory before anything reads it. The address one
    // past the end and the unused action ride along; both must do nothing.
    task automatic test_code_load();
        int a;
        for (a = 0; a < CODE_LEN; a++) begin
            send_load(t_chip'(a), 1'($urandom));
        end
        send_load(t_chip'(CODE_LEN), 1'b1);
        send_noop();
    endtask

    // Hand-picked words: register extremes, chip counter wrap, init with
    // out-of-range start and delay, zero and maximum tap offsets.
    task automatic test_directed();
        // Reset settings: a zero step leaves phase and chip counter alone.
        repeat (3) send_tick();

        // Maximum step wraps on every tick; start at the last chip so the
        // counter rolls over to zero. Zero offsets put early, prompt, late
        // and both noise taps on bit 32.
        set_config(32'hFFFF_FFFF, 5'd0, 6'd0);
        send_init(10'd1022, 32'hFFFF_FFFF, 10'd0);
        repeat (3) send_tick();
        // Start chip and travel delay of 1023 both reduce to zero.
        send_init(10'd1023, 32'h0000_0000, 10'd1023);
        repeat (2) send_tick();

        // Widest offsets: late reaches bit 63 and the noise taps clamp to
        // both ends of the line. The write to a missing register is dropped.
        set_config(32'h0000_0001, 5'd31, 6'd63);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_init(10'd0, 32'hFFFF_FFFF, 10'd1022);
        repeat (2) send_tick();

        // Noise offsets just below and above the clamp point.
        set_config(32'h8000_0000, 5'd1, 6'd31);
        send_init(10'd511, 32'h7FFF_FFFF, 10'd0);
        repeat (2) send_tick();
        send_load(t_chip'(CODE_LEN), 1'b0);
        send_noop();
        set_config(32'h8000_0000, 5'd16, 6'd33);
        repeat (2) send_tick();
    endtask

    // One block of random words under a fixed register setting. Ticks
    // dominate; loads rewrite the code under the running NCO and inits
    // jump to random code phases.
    task automatic run_random_phase(input logic [31:0] step, input logic [4:0] el_ofs,
                                    input logic [5:0] noise_ofs, input int count);
        int n;
        int r;
        set_config(step, el_ofs, noise_ofs);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                send_tick();
            end else if (r < 92) begin
                send_load(10'($urandom_range(0, CODE_LEN)), 1'($urandom));
            end else if (r < 97) begin
                send_init(10'($urandom_range(0, CODE_LEN)), $urandom,
                          10'($urandom_range(0, CODE_LEN)));
            end else begin
                send_noop();
            end
        end
    endtask

    task automatic test_random();
        run_random_phase($urandom, 5'($urandom), 6'($urandom), 170);
        run_random_phase(32'hFFFF_FFFF, 5'd31, 6'd63, 150);
        run_random_phase(32'($urandom_range(0, 32'h0010_0000)), 5'd1, 6'd0, 150);
        // A stretch with no gaps on either side.
        quiet = 1'b1;
        run_random_phase($urandom, 5'($urandom), 6'd33, 160);
        quiet = 1'b0;
        run_random_phase(32'h4000_0000 + $urandom_range(0, 255), 5'($urandom),
                         6'($urandom), 170);
    endtask

    // Hold the output off for a long stretch while ticks keep coming, so the
    // block fills up and must stall its input.
    task automatic test_backpressure();
        int n;
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            send_tick();
        end
        quiet = 1'b0;
    endtask

    // Output-side stall driver. A requested hold-off takes precedence over
    // the random stalls and is counted here, independent of the sender.
    initial begin : out_stall_driver
        int  stall_left;
        int  hold_left;
        int  gap;
        logic nxt;
        stall_left = 0;
        hold_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES - 1;
                nxt       = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b1;
            end else begin
                gap = pick_gap();
                stall_left = (gap > 0) ? gap - 1 : 0;
                nxt = (gap > 0);
            end
            i_out_stall <= nxt;
        end
    end

    // Result checker: each word taken from the block is compared field by
    // field with the oldest expected tap word.
    always @(posedge i_clk) begin : check_results
        t_nco_taps want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_taps.size() == 0) begin
                report_error("result word arrived with none expected");
            end else begin
                want = expected_taps.pop_front();
                results_checked++;
                if (o_table_index !== want.table_index) begin
                    report_error($sformatf("table_index got %0d expected %0d",
                                           o_table_index, want.table_index));
                end
                if (o_chip_index !== want.chip_index) begin
                    report_error($sformatf("chip_index got %0d expected %0d",
                                           o_chip_index, want.chip_index));
                end
                if (o_early !== want.early) begin
                    report_error($sformatf("early got %b expected %b", o_early, want.early));
                end
                if (o_prompt !== want.prompt) begin
                    report_error($sformatf("prompt got %b expected %b", o_prompt, want.prompt));
                end
                if (o_late !== want.late) begin
                    report_error($sformatf("late got %b expected %b", o_late, want.late));
                end
                if (o_super_early !== want.super_early) begin
                    report_error($sformatf("super_early got %b expected %b",
                                           o_super_early, want.super_early));
                end
                if (o_super_late !== want.super_late) begin
                    report_error($sformatf("super_late got %b expected %b",
                                           o_super_late, want.super_late));
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no word moved for %0d cycles at %0t ns", WATCHDOG_LIMIT, $time);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset once, then each test in turn, then drain.
    initial begin : main_sequence
        err_count       = 0;
        results_checked = 0;
        ticks_sent      = 0;
        loads_sent      = 0;
        inits_sent      = 0;
        noops_sent      = 0;
        quiet           = 1'b0;
        hold_req        = 1'b0;

        // Predictor starts from the reset state of the block.
        cfg_step      = '0;
        cfg_el_ofs    = 5'd8;
        cfg_noise_ofs = 6'd32;
        nco_phase     = '0;
        nco_chip      = '0;
        code_line     = '0;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_action         <= ACT_TICK;
        i_chip_addr      <= '0;
        i_chip_value     <= 1'b0;
        i_start_chip     <= '0;
        i_start_fraction <= '0;
        i_travel_delay   <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_code_load();
        test_directed();
        test_random();
        test_backpressure();

        // Drain: every owed result must arrive, then a short tail in case
        // the block emits something it should not.
        i_in_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_taps.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_taps.size()));
        end

        $display("Covered %0d ticks, %0d loads, %0d inits, %0d no-ops; %0d results checked.",
                 ticks_sent, loads_sent, inits_sent, noops_sent, results_checked);
        $display("Hit register limits, chip wrap, clamped noise taps and a long output stall.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
